// ===== rtl/lbc_pkg.sv =====
// Shared widths, register codes and lane word type for the border clip block.
`default_nettype none
package lbc_pkg;
  localparam int MAX_DIM_DEF = 4096;
  localparam int COORD_W = 12;
  localparam int DIM_W = 13;
  localparam int FIX_W = DIM_W + 1;
  localparam int NUM_W = 28;
  localparam int DEN_W = 12;
  localparam int DV_W = DEN_W + 1;
  localparam int QW = 13;
  localparam int LANES = 4;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_WIDTH = 1'b0;
  localparam reg_idx_t REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic             ok;
    logic [NUM_W-1:0] dividend;
    logic [DV_W-1:0]  divisor;
  } lane_t;
endpackage
`default_nettype wire

// ===== rtl/lbc_front.sv =====
// Line coefficients, border numerators and range tests in four pipeline stages.
`default_nettype none
module lbc_front
  import lbc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_ok,
  input  wire logic [COORD_W-1:0]      x1,
  input  wire logic [COORD_W-1:0]      y1,
  input  wire logic [COORD_W-1:0]      x2,
  input  wire logic [COORD_W-1:0]      y2,
  input  wire logic [DIM_W-1:0]        w,
  input  wire logic [DIM_W-1:0]        h,
  output logic                         valid,
  output lane_t                        lanes [LANES],
  output logic signed [FIX_W-1:0]      fr,
  output logic signed [FIX_W-1:0]      fb
);
  localparam int PW = 2 * COORD_W;

  logic                     v1, v2, v3;
  logic signed [DIM_W-1:0]  a1, b1, a2, b2;
  logic [PW-1:0]            p1, p2;
  logic signed [FIX_W-1:0]  fr1, fb1, fr2, fb2, fr3, fb3;
  logic [DIM_W-1:0]         w1, h1, w2, h2;
  logic signed [PW+1:0]     c2;
  logic signed [DIM_W+FIX_W-1:0] ma2, mb2;
  logic signed [NUM_W-1:0]  n3 [LANES];
  logic [DEN_W-1:0]         m3 [LANES];
  logic                     e3 [LANES];
  logic [DIM_W-1:0]         lim3 [LANES];

  logic signed [NUM_W-1:0]  t [LANES];
  logic signed [DIM_W-1:0]  d [LANES];
  logic                     ex [LANES];
  logic [DIM_W-1:0]         lm [LANES];

  always_comb begin
    t[0] = -NUM_W'(c2);
    t[1] = -(NUM_W'(ma2) + NUM_W'(c2));
    t[2] = -NUM_W'(c2);
    t[3] = -(NUM_W'(mb2) + NUM_W'(c2));
    d[0] = b2;
    d[1] = b2;
    d[2] = a2;
    d[3] = a2;
    ex[0] = 1'b1;
    ex[1] = fr2 >= 0;
    ex[2] = 1'b1;
    ex[3] = fb2 >= 0;
    lm[0] = h2;
    lm[1] = h2;
    lm[2] = w2;
    lm[3] = w2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1 <= in_ok;
      v2 <= v1;
      v3 <= v2;
      valid <= v3;
    end
    if (en) begin
      a1 <= $signed({1'b0, y2}) - $signed({1'b0, y1});
      b1 <= $signed({1'b0, x1}) - $signed({1'b0, x2});
      p1 <= x2 * y1;
      p2 <= x1 * y2;
      fr1 <= $signed({1'b0, w}) - FIX_W'(1);
      fb1 <= $signed({1'b0, h}) - FIX_W'(1);
      w1 <= w;
      h1 <= h;

      c2 <= $signed({2'b00, p1}) - $signed({2'b00, p2});
      ma2 <= a1 * fr1;
      mb2 <= b1 * fb1;
      a2 <= a1;
      b2 <= b1;
      fr2 <= fr1;
      fb2 <= fb1;
      w2 <= w1;
      h2 <= h1;

      for (int k = 0; k < LANES; k++) begin
        n3[k] <= (d[k] < 0) ? -t[k] : t[k];
        m3[k] <= (d[k] < 0) ? DEN_W'(-d[k]) : DEN_W'(d[k]);
        e3[k] <= ex[k] && (d[k] != 0);
        lim3[k] <= lm[k];
      end
      fr3 <= fr2;
      fb3 <= fb2;

      for (int k = 0; k < LANES; k++) begin
        lanes[k].ok <= e3[k] && (n3[k] >= 0) &&
                       (n3[k] <= $signed(NUM_W'(lim3[k]) * NUM_W'(m3[k])));
        lanes[k].dividend <= NUM_W'(n3[k] + n3[k] + $signed({1'b0, m3[k]}));
        lanes[k].divisor <= {m3[k], 1'b0};
      end
      fr <= fr3;
      fb <= fb3;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/lbc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module lbc_div
  import lbc_pkg::*;
#(
  parameter int QBITS = QW,
  parameter int REM_W = NUM_W,
  parameter int DIV_W = DV_W
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [REM_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic [QBITS-1:0]      quotient
);
  logic [REM_W-1:0] rem [QBITS];
  logic [DIV_W-1:0] dv  [QBITS];
  logic [QBITS-1:0] q   [QBITS];
  logic [REM_W-1:0] rin [QBITS];
  logic [DIV_W-1:0] dvin [QBITS];
  logic [QBITS-1:0] qin [QBITS];
  logic [REM_W-1:0] sh [QBITS];

  always_comb begin
    for (int s = 0; s < QBITS; s++) begin
      rin[s]  = (s == 0) ? dividend : rem[(s == 0) ? 0 : s - 1];
      dvin[s] = (s == 0) ? divisor : dv[(s == 0) ? 0 : s - 1];
      qin[s]  = (s == 0) ? '0 : q[(s == 0) ? 0 : s - 1];
      sh[s]   = REM_W'(dvin[s]) << (QBITS - 1 - s);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QBITS; s++) begin
        dv[s] <= dvin[s];
        if (rin[s] >= sh[s]) begin
          rem[s] <= rin[s] - sh[s];
          q[s] <= qin[s] | (QBITS'(1) << (QBITS - 1 - s));
        end else begin
          rem[s] <= rin[s];
          q[s] <= qin[s];
        end
      end
    end
  end

  assign quotient = q[QBITS-1];
endmodule
`default_nettype wire

// ===== rtl/line_image_border_clip.sv =====
// Top level: config registers, front stages, four dividers and result select.
//
// Input channel: in_valid/in_stall carries two points (first_x, first_y,
// second_x, second_y) per word. Output channel: out_valid/out_stall carries
// found_two and the two rounded border points end_a and end_b; unfound
// points read zero.
// A new word is taken every cycle while in_stall is low. From input to the
// output register a word passes four front stages (coefficients, products,
// numerators, range test), thirteen divider stages (one quotient bit each,
// set by the 13-bit result width) and one select stage.
// image_width (index 0) and image_height (index 1) are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is
// idle, which the block does not enforce; values above MAX_DIM saturate to MAX_DIM.
// Reset empties the pipeline and loads 640 by 480.
// While out_valid is high and out_stall is high the whole pipeline holds
// and in_stall is raised; nothing is dropped or repeated.
`default_nettype none
module line_image_border_clip
  import lbc_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire reg_idx_t           cfg_index,
  input  wire logic [DIM_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [COORD_W-1:0] first_x,
  input  wire logic [COORD_W-1:0] first_y,
  input  wire logic [COORD_W-1:0] second_x,
  input  wire logic [COORD_W-1:0] second_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    found_two,
  output logic [DIM_W-1:0]        end_a_x,
  output logic [DIM_W-1:0]        end_a_y,
  output logic [DIM_W-1:0]        end_b_x,
  output logic [DIM_W-1:0]        end_b_y
);
  logic [DIM_W-1:0] image_width, image_height, w, h;
  logic en;
  logic fvalid;
  lane_t lanes [LANES];
  logic signed [FIX_W-1:0] ffr, ffb;
  logic [QW-1:0] quo [LANES];

  logic dv [QW];
  logic [LANES-1:0] dok [QW];
  logic [DIM_W-1:0] dfr [QW];
  logic [DIM_W-1:0] dfb [QW];

  logic [DIM_W-1:0] px [LANES];
  logic [DIM_W-1:0] py [LANES];
  logic [DIM_W-1:0] ax_next, ay_next, bx_next, by_next;
  logic [2:0] cnt;

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;
  assign w = (32'(image_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : image_width;
  assign h = (32'(image_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= DIM_W'(640);
      image_height <= DIM_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  lbc_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_ok(in_valid),
    .x1(first_x), .y1(first_y), .x2(second_x), .y2(second_y),
    .w(w), .h(h), .valid(fvalid), .lanes(lanes), .fr(ffr), .fb(ffb)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_div
    lbc_div #(.QBITS(QW), .REM_W(NUM_W), .DIV_W(DV_W)) u_div (
      .clk(clk), .en(en), .dividend(lanes[k].dividend),
      .divisor(lanes[k].divisor), .quotient(quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < QW; s++) dv[s] <= 1'b0;
    end else if (en) begin
      dv[0] <= fvalid;
      for (int s = 1; s < QW; s++) dv[s] <= dv[s-1];
    end
    if (en) begin
      for (int k = 0; k < LANES; k++) dok[0][k] <= lanes[k].ok;
      dfr[0] <= ffr[DIM_W-1:0];
      dfb[0] <= ffb[DIM_W-1:0];
      for (int s = 1; s < QW; s++) begin
        dok[s] <= dok[s-1];
        dfr[s] <= dfr[s-1];
        dfb[s] <= dfb[s-1];
      end
    end
  end

  always_comb begin
    px[0] = '0;
    py[0] = quo[0];
    px[1] = dfr[QW-1];
    py[1] = quo[1];
    px[2] = quo[2];
    py[2] = '0;
    px[3] = quo[3];
    py[3] = dfb[QW-1];
    ax_next = '0;
    ay_next = '0;
    bx_next = '0;
    by_next = '0;
    cnt = '0;
    for (int k = 0; k < LANES; k++) begin
      if (dok[QW-1][k]) begin
        if (cnt == 3'd0) begin
          ax_next = px[k];
          ay_next = py[k];
        end else if (cnt == 3'd1) begin
          bx_next = px[k];
          by_next = py[k];
        end
        cnt = cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW-1];
    end
    if (en) begin
      found_two <= cnt >= 3'd2;
      end_a_x <= ax_next;
      end_a_y <= ay_next;
      end_b_x <= bx_next;
      end_b_y <= by_next;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (en && dv[QW-1]) |=> out_valid)
    else $error("pipeline word lost at output");
  a_zero_b: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found_two) |-> (end_b_x == '0 && end_b_y == '0))
    else $error("second point not zero without two hits");
endmodule
`default_nettype wire
